### hdl/smooth_weighted_round_robin_unit_defines.svh
// ---------------------------------------------------------------------------
// Smooth weighted round-robin unit: assertion macros
// Concurrent assertion helpers, compiled away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_UNIT_DEFINES_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define SWRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swrr assertion failed");
// Expression must never be true outside reset.
`define SWRR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("swrr forbidden condition seen");
`else
`define SWRR_ASSERT(lbl, clk, rst_n, prop)
`define SWRR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### hdl/swrr_pkg.sv
// ---------------------------------------------------------------------------
// Smooth weighted round-robin package
// Widths, constants and shared types of the selector.
// ---------------------------------------------------------------------------
package swrr_pkg;

    // Number of endpoints that take part in selection (1 to 8).
    localparam int ENDPOINTS = 8;
    // Number of weight registers.
    localparam int NREG      = 8;

    localparam int IDX_W   = 3;   // endpoint index
    localparam int CIDX_W  = 4;   // configuration register index
    localparam int W_W     = 8;   // weight
    localparam int RW_W    = 13;  // running weight, signed
    localparam int TOT_W   = 11;  // weight total
    localparam int TAG_W   = 8;   // request tag

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WBACK,
        ST_DONE
    } t_state;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_state             state;
        logic [IDX_W-1:0]   idx;
        logic               scan;
        logic               wback;
        logic               load_out;
    } t_seq_ctrl;

endpackage

### hdl/swrr_sat_alu.sv
// ---------------------------------------------------------------------------
// Saturating adder and compare
// Shared unit: running weight plus a signed operand, clamped to the 13-bit
// signed range, and a signed greater-than against the best weight so far.
// ---------------------------------------------------------------------------
module swrr_sat_alu (
    input  logic signed [swrr_pkg::RW_W-1:0] i_a,
    input  logic signed [swrr_pkg::RW_W:0]   i_b,
    input  logic signed [swrr_pkg::RW_W-1:0] i_cmp,
    output logic signed [swrr_pkg::RW_W-1:0] o_sum,
    output logic                             o_gt
);
    import swrr_pkg::*;

    logic signed [RW_W+1:0] w_sum;
    logic                   w_hi;
    logic                   w_lo;

    // Full-width sum, two guard bits above the running weight.
    assign w_sum = {{2{i_a[RW_W-1]}}, i_a} + {i_b[RW_W], i_b};

    // Overflow detection from the guard bits.
    assign w_hi = ~w_sum[RW_W+1] & (w_sum[RW_W] | w_sum[RW_W-1]);
    assign w_lo =  w_sum[RW_W+1] & ~(w_sum[RW_W] & w_sum[RW_W-1]);

    // Clamp to the signed range.
    always_comb begin
        if (w_hi) begin
            o_sum = {1'b0, {(RW_W-1){1'b1}}};
        end else if (w_lo) begin
            o_sum = {1'b1, {(RW_W-1){1'b0}}};
        end else begin
            o_sum = w_sum[RW_W-1:0];
        end
    end

    assign o_gt = (o_sum > i_cmp);

endmodule

### hdl/swrr_seq.sv
// ---------------------------------------------------------------------------
// Selection sequencer
// Walks the endpoints one per cycle, then one write-back cycle for the
// winner, then hands the result to the output register.
// ---------------------------------------------------------------------------
module swrr_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    output swrr_pkg::t_seq_ctrl   o_ctrl
);
    import swrr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENDPOINTS - 1);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    // State and index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        o_ctrl.state    = r_state;
        o_ctrl.idx      = r_idx;
        o_ctrl.scan     = 1'b0;
        o_ctrl.wback    = 1'b0;
        o_ctrl.load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                o_ctrl.scan = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_WBACK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_WBACK: begin
                o_ctrl.wback = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/smooth_weighted_round_robin_unit.sv
// Requests are taken only in the idle state: a new one is not accepted until the
// last has been handed to the output register. The single saturating adder
// visits each endpoint in turn, then the winner; the request is accepted before
// the scan and the result handed off after the write-back, once the output is free.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low): weights 1, running weights 1, total ENDPOINTS.
// ---------------------------------------------------------------------------
// Smooth weighted round-robin unit
// Per request adds each weight to its running weight, picks the largest
// positive running weight (lowest index on ties) and charges it the total.
// ---------------------------------------------------------------------------
`include "smooth_weighted_round_robin_unit_defines.svh"

module smooth_weighted_round_robin_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [swrr_pkg::TAG_W-1:0]    i_request_tag,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [swrr_pkg::IDX_W-1:0]    o_chosen_index,
    output logic                          o_pick_valid,
    output logic [swrr_pkg::TAG_W-1:0]    o_tag_echo,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swrr_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [swrr_pkg::W_W-1:0]      i_cfg_data
);
    import swrr_pkg::*;

    t_seq_ctrl               w_ctrl;
    logic                    w_start;
    logic                    w_out_free;
    logic                    w_cfg_wr;
    logic [IDX_W-1:0]        w_rd_idx;
    logic signed [RW_W-1:0]  w_alu_a;
    logic signed [RW_W:0]    w_alu_b;
    logic signed [RW_W-1:0]  w_alu_sum;
    logic                    w_alu_gt;

    logic [W_W-1:0]          r_weight [NREG];
    logic signed [RW_W-1:0]  r_rw     [NREG];
    logic [TOT_W-1:0]        r_total;
    logic [IDX_W-1:0]        r_best_idx;
    logic signed [RW_W-1:0]  r_best_w;
    logic                    r_best_hit;
    logic [TAG_W-1:0]        r_tag;
    logic                    r_out_valid;

    // Handshakes.
    assign o_in_ready  = (w_ctrl.state == ST_IDLE);
    assign o_cfg_ready = (w_ctrl.state == ST_IDLE);
    assign w_start     = i_in_valid & o_in_ready;
    assign w_out_free  = ~r_out_valid | i_out_ready;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready & (i_cfg_index < CIDX_W'(NREG));

    swrr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Operand selection for the shared adder.
    assign w_rd_idx = w_ctrl.wback ? r_best_idx : w_ctrl.idx;
    assign w_alu_a  = r_rw[w_rd_idx];
    assign w_alu_b  = w_ctrl.wback ? ((RW_W+1)'(0) - {{(RW_W+1-TOT_W){1'b0}}, r_total})
                                   : {{(RW_W+1-W_W){1'b0}}, r_weight[w_ctrl.idx]};

    swrr_sat_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_cmp (r_best_w),
        .o_sum (w_alu_sum),
        .o_gt  (w_alu_gt)
    );

    // Weights, running weights and total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREG; k++) begin
                r_weight[k] <= W_W'(1);
                r_rw[k]     <= RW_W'(1);
            end
            r_total <= TOT_W'(ENDPOINTS);
        end else if (w_cfg_wr) begin
            r_weight[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
            r_rw[i_cfg_index[IDX_W-1:0]]     <= {{(RW_W-W_W){1'b0}}, i_cfg_data};
            if (i_cfg_index < CIDX_W'(ENDPOINTS)) begin
                r_total <= r_total - TOT_W'(r_weight[i_cfg_index[IDX_W-1:0]])
                                   + TOT_W'(i_cfg_data);
            end
        end else if (w_ctrl.scan) begin
            r_rw[w_ctrl.idx] <= w_alu_sum;
        end else if (w_ctrl.wback && r_best_hit) begin
            r_rw[r_best_idx] <= w_alu_sum;
        end
    end

    // Best candidate tracking during the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_hit <= 1'b0;
            r_best_w   <= '0;
            r_best_idx <= '0;
        end else if (w_start) begin
            r_best_hit <= 1'b0;
            r_best_w   <= '0;
            r_best_idx <= '0;
        end else if (w_ctrl.scan && (r_total != '0) && w_alu_gt) begin
            r_best_hit <= 1'b1;
            r_best_w   <= w_alu_sum;
            r_best_idx <= w_ctrl.idx;
        end
    end

    // Request tag capture.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_tag <= i_request_tag;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            o_chosen_index <= r_best_hit ? r_best_idx : '0;
            o_pick_valid   <= r_best_hit;
            o_tag_echo     <= r_tag;
        end
    end

    assign o_out_valid = r_out_valid;

    // A new result beat appears only out of the hand-off state.
    `SWRR_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_ctrl.state == ST_DONE))
    // A winner always has a strictly positive running weight.
    `SWRR_ASSERT(a_best_positive, i_clk, i_rst_n, r_best_hit |-> (r_best_w > 0))
    // No winner can be charged when the total weight is zero.
    `SWRR_ASSERT_NEVER(a_no_charge_zero, i_clk, i_rst_n, w_ctrl.wback && r_best_hit && (r_total == '0))
    // A valid pick names an endpoint that takes part.
    `SWRR_ASSERT(a_index_range, i_clk, i_rst_n, (r_out_valid && o_pick_valid) |-> (o_chosen_index <= IDX_W'(ENDPOINTS - 1)))

endmodule

### test/smooth_weighted_round_robin_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Smooth weighted round-robin unit: checker
// Watches the request, result and configuration channels. It keeps its own
// copy of the weights and running credits, works out the pick for every
// request beat, and compares each result beat with the oldest pick waiting.
// ---------------------------------------------------------------------------
module smooth_weighted_round_robin_unit_checker
    import swrr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [TAG_W-1:0]     i_request_tag,
    // result channel
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [IDX_W-1:0]     i_chosen_index,
    input  logic                 i_pick_valid,
    input  logic [TAG_W-1:0]     i_tag_echo,
    // configuration channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CIDX_W-1:0]    i_cfg_index,
    input  logic [W_W-1:0]       i_cfg_data,
    // status to the testbench top
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int CREDIT_MAX = (1 << (RW_W - 1)) - 1;
    localparam int CREDIT_MIN = -(1 << (RW_W - 1));
    localparam int REPORT_LIMIT = 10;

    // One selection outcome as seen on the result channel.
    typedef struct packed {
        logic [IDX_W-1:0] chosen;
        logic             picked;
        logic [TAG_W-1:0] tag;
    } t_pick;

    logic [W_W-1:0]         weight [NREG];
    logic signed [RW_W-1:0] credit [NREG];
    logic [TOT_W-1:0]       weight_sum;
    t_pick                  pick_queue [$];
    int                     mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Credits saturate at both ends of their signed range.
    function automatic logic signed [RW_W-1:0] clamp_credit(input int value);
        int c;
        c = value;
        if (c > CREDIT_MAX) begin
            c = CREDIT_MAX;
        end else if (c < CREDIT_MIN) begin
            c = CREDIT_MIN;
        end
        return RW_W'(c);
    endfunction

    // Only the endpoints that take part count toward the total.
    function automatic void refresh_weight_sum();
        int s;
        s = 0;
        for (int i = 0; i < ENDPOINTS; i++) begin
            s += int'(weight[i]);
        end
        weight_sum = TOT_W'(s);
    endfunction

    function automatic void reset_selector();
        for (int i = 0; i < NREG; i++) begin
            weight[i] = W_W'(1);
            credit[i] = RW_W'(1);
        end
        refresh_weight_sum();
    endfunction

    // Add every weight to its credit, pick the largest positive credit
    // (lowest index wins ties) and charge the winner the total weight.
    function automatic t_pick predict_pick(input logic [TAG_W-1:0] tag);
        int    best;
        int    best_credit;
        t_pick p;
        best        = -1;
        best_credit = 0;
        for (int i = 0; i < ENDPOINTS; i++) begin
            credit[i] = clamp_credit(int'(credit[i]) + int'(weight[i]));
        end
        if (weight_sum != '0) begin
            for (int i = 0; i < ENDPOINTS; i++) begin
                if (int'(credit[i]) > best_credit) begin
                    best_credit = int'(credit[i]);
                    best        = i;
                end
            end
        end
        if (best >= 0) begin
            credit[best] = clamp_credit(int'(credit[best]) - int'(weight_sum));
            p.chosen     = IDX_W'(best);
            p.picked     = 1'b1;
        end else begin
            p.chosen = '0;
            p.picked = 1'b0;
        end
        p.tag = tag;
        return p;
    endfunction

    function automatic void flag_mismatch(input string what, input t_pick want,
                                          input t_pick got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected chosen=%0d picked=%0b tag=%02h",
                     $time, what, want.chosen, want.picked, want.tag);
            $display("%0t: %s: actual   chosen=%0d picked=%0b tag=%02h",
                     $time, what, got.chosen, got.picked, got.tag);
        end
    endfunction

    // Results are checked before the request of the same edge is predicted,
    // so a result can never be matched against its own request too early.
    always @(posedge i_clk) begin : watch
        t_pick want;
        t_pick got;
        if (!i_rst_n) begin
            reset_selector();
            pick_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{chosen: i_chosen_index, picked: i_pick_valid, tag: i_tag_echo};
                if (pick_queue.size() == 0) begin
                    flag_mismatch("result beat with no request pending", '0, got);
                end else begin
                    want = pick_queue.pop_front();
                    if (got.chosen !== want.chosen || got.picked !== want.picked ||
                        got.tag !== want.tag) begin
                        flag_mismatch("result beat mismatch", want, got);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready && int'(i_cfg_index) < NREG) begin
                weight[i_cfg_index] = i_cfg_data;
                credit[i_cfg_index] = RW_W'(i_cfg_data);
                refresh_weight_sum();
            end
            if (i_in_valid && i_in_ready) begin
                pick_queue.push_back(predict_pick(i_request_tag));
            end
        end
        o_pending = pick_queue.size();
    end

endmodule

### test/smooth_weighted_round_robin_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Smooth weighted round-robin unit: testbench top
// Drives request beats and weight writes, throttles the result channel, and
// gives the verdict from the checker's mismatch count. A short directed part
// covers the reset weights, the extremes, ties and the no-pick cases; random
// phases then sweep weight settings and every idle pattern.
// ---------------------------------------------------------------------------
module smooth_weighted_round_robin_unit_tb;
    import swrr_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 2 * (ENDPOINTS + 3);
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 144;

    // Register map: weights first, everything past them is unused.
    localparam logic [CIDX_W-1:0] REG_WEIGHT_0    = 4'd0;
    localparam logic [CIDX_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [CIDX_W-1:0] REG_SPARE_LAST  = 4'd15;

    typedef enum {
        MODE_FREE,
        MODE_SEND_IDLE,
        MODE_RECV_STALL,
        MODE_BOTH
    } t_idle_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [TAG_W-1:0]   i_request_tag = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [IDX_W-1:0]   o_chosen_index;
    logic               o_pick_valid;
    logic [TAG_W-1:0]   o_tag_echo;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index   = '0;
    logic [W_W-1:0]     i_cfg_data    = '0;

    int                 fail_count;
    int                 pending_picks;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 cycle_count   = 0;
    logic [TAG_W-1:0]   tag_backlog [$];

    smooth_weighted_round_robin_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_request_tag  (i_request_tag),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_chosen_index (o_chosen_index),
        .o_pick_valid   (o_pick_valid),
        .o_tag_echo     (o_tag_echo),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    smooth_weighted_round_robin_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_request_tag  (i_request_tag),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_chosen_index (o_chosen_index),
        .i_pick_valid   (o_pick_valid),
        .i_tag_echo     (o_tag_echo),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_picks)
    );

    // 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random, one decision per cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("smooth_weighted_round_robin_unit test failed");
            $finish;
        end
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            MODE_FREE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            MODE_SEND_IDLE: begin
                send_idle_pct = 79;
                stall_pct     = 0;
            end
            MODE_RECV_STALL: begin
                send_idle_pct = 0;
                stall_pct     = 79;
            end
            default: begin
                send_idle_pct = 37;
                stall_pct     = 37;
            end
        endcase
    endtask

    // Send every queued tag; valid stays up across back-to-back beats and
    // only drops when the sender goes idle or the last tag has been taken.
    task automatic drive_requests();
        while (tag_backlog.size() != 0) begin
            i_in_valid    <= 1'b1;
            i_request_tag <= tag_backlog.pop_front();
            do @(posedge i_clk); while (!o_in_ready);
            if (tag_backlog.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
            end
        end
    endtask

    task automatic write_weight(input logic [CIDX_W-1:0] index,
                                input logic [W_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted pick has come back.
    task automatic drain_picks();
        @(posedge i_clk);
        while (pending_picks != 0) @(posedge i_clk);
    endtask

    task automatic run_requests(input logic [TAG_W-1:0] tags [$]);
        tag_backlog = tags;
        drive_requests();
        drain_picks();
    endtask

    initial begin : stimulus
        logic [W_W-1:0]   value;
        logic [TAG_W-1:0] tags [$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling.
        set_idle_mode(MODE_FREE);

        // Reset weights: eight requests walk every endpoint once.
        run_requests('{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE});

        // All weights at maximum; endpoint 0 wins and goes deep into debt.
        for (int i = 0; i < NREG; i++) begin
            write_weight(CIDX_W'(REG_WEIGHT_0 + i), 8'hFF);
        end
        run_requests('{8'h11});

        // Only endpoint 0 left, still in debt: no positive credit, no pick.
        for (int i = 1; i < NREG; i++) begin
            write_weight(CIDX_W'(REG_WEIGHT_0 + i), 8'h00);
        end
        run_requests('{8'h22, 8'h33});

        // Every weight zero.
        write_weight(REG_WEIGHT_0, 8'h00);
        run_requests('{8'h44, 8'h66});

        // Writes past the last weight register must change nothing.
        write_weight(REG_SPARE_FIRST, 8'hFF);
        write_weight(REG_SPARE_LAST, 8'hFF);
        run_requests('{8'h77});

        // Two equal weights: the lower index takes the tie.
        write_weight(CIDX_W'(REG_WEIGHT_0 + 2), 8'd5);
        write_weight(CIDX_W'(REG_WEIGHT_0 + 5), 8'd5);
        run_requests('{8'h88, 8'h99, 8'hC3, 8'h3C});

        // Largest weight against the smallest.
        write_weight(CIDX_W'(REG_WEIGHT_0 + 7), 8'hFF);
        write_weight(CIDX_W'(REG_WEIGHT_0 + 3), 8'h01);
        run_requests('{8'hBB, 8'hDD, 8'hEE});

        // Random phases: each idle pattern twice, a new weight setting each.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idle_mode(t_idle_mode'(phase % 4));
            value = '0;
            for (int i = 0; i < NREG; i++) begin
                case (phase)
                    0: value = 8'hFF;
                    1: value = ($urandom_range(1) == 0) ? 8'h00 : W_W'($urandom);
                    2: value = 8'h01;
                    3: value = 8'h00;
                    5: begin
                        case ($urandom_range(2))
                            0:       value = 8'h00;
                            1:       value = 8'h01;
                            default: value = 8'hFF;
                        endcase
                    end
                    6: value = W_W'($urandom_range(4, 1));
                    default: value = W_W'($urandom);
                endcase
                // The last phase rewrites only some weights, so the
                // credits of the others carry over.
                if (phase != 7 || $urandom_range(1) == 0) begin
                    write_weight(CIDX_W'(REG_WEIGHT_0 + i), value);
                end
            end
            // A single active endpoint at full weight.
            if (phase == 3) begin
                write_weight(CIDX_W'(REG_WEIGHT_0 + $urandom_range(NREG - 1)), 8'hFF);
            end
            if ($urandom_range(3) == 0) begin
                write_weight(CIDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                             W_W'($urandom));
            end
            tags.delete();
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                tags.push_back(TAG_W'($urandom));
            end
            run_requests(tags);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("smooth_weighted_round_robin_unit test passed");
        end else begin
            $display("smooth_weighted_round_robin_unit test failed");
        end
        $finish;
    end

endmodule

### smooth_weighted_round_robin_unit.f
+incdir+hdl
hdl/swrr_pkg.sv
hdl/swrr_sat_alu.sv
hdl/swrr_seq.sv
hdl/smooth_weighted_round_robin_unit.sv
test/smooth_weighted_round_robin_unit_checker.sv
test/smooth_weighted_round_robin_unit_tb.sv
